/* hdl/tsrm_pkg.sv */
package tsrm_pkg;

	localparam int PW    = 48;
	localparam int BW    = 25;
	localparam int NW    = 80;
	localparam int CNT_W = $clog2(NW);

	localparam logic signed [17:0] SUN_X_RST   = 18'sd0;
	localparam logic signed [17:0] SUN_Y_RST   = 18'sd0;
	localparam logic signed [17:0] SUN_Z_RST   = 18'sd65536;
	localparam logic [23:0]        CELL_D_RST  = 24'd25600;
	localparam logic [8:0]         USED_RST    = 9'd256;
	localparam logic signed [23:0] CEILING_RST = 24'sd2265088;

	typedef enum logic [2:0] {
		CFG_SUN_X   = 3'd0,
		CFG_SUN_Y   = 3'd1,
		CFG_SUN_Z   = 3'd2,
		CFG_CELL_DX = 3'd3,
		CFG_CELL_DY = 3'd4,
		CFG_ROWS    = 3'd5,
		CFG_COLS    = 3'd6,
		CFG_CEILING = 3'd7
	} cfg_idx_t;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [7:0]        row;
		logic [7:0]        col;
		logic signed [23:0] elevation;
	} req_t;

	typedef struct packed {
		logic       shadowed;
		logic [7:0] out_row;
		logic [7:0] out_col;
	} rsp_t;

	typedef struct packed {
		logic signed [PW-1:0] a;
		logic signed [BW-1:0] b;
		logic signed [BW-1:0] den;
		logic                 sat;
	} md_req_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV,
		MD_FIN
	} md_st_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_Z0,
		ST_LOOP,
		ST_R1,
		ST_DEC,
		ST_R2,
		ST_STEP,
		ST_ZR,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_INT,
		ST_IW,
		ST_CMP,
		ST_DONE
	} st_t;

endpackage

/* hdl/tsrm_ram.sv */
module tsrm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/tsrm_muldiv.sv */
module tsrm_muldiv
	import tsrm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  md_req_t              req,
	output logic                 busy,
	output logic                 done,
	output logic signed [NW-1:0] q
);

	md_st_t st_q, st_d;

	logic [NW-1:0]    mcand_q;
	logic [BW-1:0]    mplier_q;
	logic [NW-1:0]    acc_q;
	logic [BW-1:0]    den_q;
	logic [BW-1:0]    rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic             sat_q;
	logic             done_q;
	logic signed [NW-1:0] q_q;

	logic [PW-1:0]        a_mag;
	logic [BW-1:0]        b_mag;
	logic [BW-1:0]        d_mag;
	logic [BW:0]          rem_sh;
	logic                 qbit;
	logic signed [NW-1:0] q_signed;
	logic signed [NW-1:0] q_final;

	localparam logic signed [NW-1:0] SAT_MAX = NW'(64'sd2147483647);
	localparam logic signed [NW-1:0] SAT_MIN = -NW'(64'sd2147483648);

	always_comb begin
		a_mag = req.a[PW-1] ? PW'(-req.a) : PW'(req.a);
		b_mag = req.b[BW-1] ? BW'(-req.b) : BW'(req.b);
		d_mag = req.den[BW-1] ? BW'(-req.den) : BW'(req.den);
		rem_sh = {rem_q, acc_q[NW-1]};
		qbit = (rem_sh >= {1'b0, den_q});
		q_signed = neg_q ? -$signed(acc_q) : $signed(acc_q);
		if (sat_q && q_signed > SAT_MAX) begin
			q_final = SAT_MAX;
		end else if (sat_q && q_signed < SAT_MIN) begin
			q_final = SAT_MIN;
		end else begin
			q_final = q_signed;
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			MD_IDLE: if (start) st_d = MD_MUL;
			MD_MUL:  if (cnt_q == CNT_W'(BW - 1)) st_d = MD_DIV;
			MD_DIV:  if (cnt_q == CNT_W'(NW - 1)) st_d = MD_FIN;
			MD_FIN:  st_d = MD_IDLE;
			default: st_d = MD_IDLE;
		endcase
	end

	always_comb begin
		busy = (st_q != MD_IDLE);
		done = done_q;
		q    = q_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= MD_IDLE;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= (st_q == MD_FIN);
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			MD_IDLE: begin
				mcand_q  <= NW'(a_mag);
				mplier_q <= b_mag;
				den_q    <= d_mag;
				acc_q    <= '0;
				rem_q    <= '0;
				cnt_q    <= '0;
				neg_q    <= req.a[PW-1] ^ req.b[BW-1] ^ req.den[BW-1];
				sat_q    <= req.sat;
			end
			MD_MUL: begin
				if (mplier_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q  <= {mcand_q[NW-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[BW-1:1]};
				cnt_q    <= (cnt_q == CNT_W'(BW - 1)) ? '0 : cnt_q + 1'b1;
			end
			MD_DIV: begin
				rem_q <= qbit ? BW'(rem_sh - {1'b0, den_q}) : BW'(rem_sh);
				acc_q <= {acc_q[NW-2:0], qbit};
				cnt_q <= cnt_q + 1'b1;
			end
			MD_FIN: begin
				q_q <= q_final;
			end
			default: ;
		endcase
	end

endmodule

/* hdl/terrain_shadow_ray_march_top.sv */
// Channel  Handshake         Payload       Notes
// request  start / busy      req (req_t)   taken when start && !busy
// result   done (strobe)     rsp (rsp_t)   one cycle, cannot be held off
// config   cfg_we            cfg_idx/wdata written on every edge with cfg_we
// A write transaction leaves busy low.
// Each grid crossing of a query runs up to three saturating ratios and one
// interpolation through the shared serial multiply/divide unit, plus two
// elevation reads. Crossings per query are at most rows + cols in use.
// Reset returns control and configuration to their defaults; the elevation store is not cleared.
module terrain_shadow_ray_march_top
	import tsrm_pkg::*;
#(
	parameter int MAX_ROWS = 256,
	parameter int MAX_COLS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [23:0] cfg_wdata
);

	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);
	localparam int AW = RW + CW;
	localparam int IW = (RW > CW) ? RW : CW;
	localparam int XW = ((IW > 8) ? IW : 8) + 2;

	st_t st_q, st_d;

	logic signed [17:0] sx_q, sy_q, sz_q;
	logic [23:0]        dx_q, dy_q;
	logic [8:0]         rows_q, cols_q;
	logic signed [23:0] ceil_q;

	logic [7:0]           qrow_q, qcol_q;
	logic signed [XW-1:0] rr_q, cc_q;
	logic signed [PW-1:0] gx_q, gy_q, xp_q, yp_q, zr_q, t1_q, np_q;
	logic                 col_q, hit_q;
	logic signed [23:0]   z1_q, z2_q;
	logic signed [NW:0]   zt_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [23:0]   ram_rdata;

	logic                 md_start, md_busy, md_done;
	md_req_t              md_req;
	logic signed [NW-1:0] md_q;

	logic signed [XW-1:0] nr, nc, ox, oy, r0, c0;
	logic signed [PW-1:0] oxdx, oydy, dxc, dyr, yv, xv, ady, adx, off, aint;
	logic signed [18:0]   sx19, sy19, sxa, sya;
	logic                 xmaj, in_grid, cond, col_dec, trivial;
	logic [XW-1:0]        wr_row, wr_col;

	tsrm_ram #(.WIDTH(24), .DEPTH(1 << AW)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (req.elevation),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tsrm_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.req    (md_req),
		.busy   (md_busy),
		.done   (md_done),
		.q      (md_q)
	);

	always_comb begin
		nr = (rows_q < 9'(MAX_ROWS)) || (MAX_ROWS > 511) ? XW'(rows_q) : XW'(MAX_ROWS);
		nc = (cols_q < 9'(MAX_COLS)) || (MAX_COLS > 511) ? XW'(cols_q) : XW'(MAX_COLS);
		if (XW'(MAX_ROWS) < XW'(rows_q)) nr = XW'(MAX_ROWS);
		if (XW'(MAX_COLS) < XW'(cols_q)) nc = XW'(MAX_COLS);
		ox   = (sx_q > 0) ? XW'(1) : ((sx_q < 0) ? -XW'(1) : XW'(0));
		oy   = (sy_q > 0) ? XW'(1) : ((sy_q < 0) ? -XW'(1) : XW'(0));
		oxdx = (sx_q > 0) ? PW'(dx_q) : ((sx_q < 0) ? -PW'(dx_q) : PW'(0));
		oydy = (sy_q > 0) ? PW'(dy_q) : ((sy_q < 0) ? -PW'(dy_q) : PW'(0));
		sx19 = 19'(sx_q);
		sy19 = 19'(sy_q);
		sxa  = (sx19 < 0) ? -sx19 : sx19;
		sya  = (sy19 < 0) ? -sy19 : sy19;
		xmaj = sxa > sya;
		r0   = XW'(qrow_q);
		c0   = XW'(qcol_q);
		in_grid = !(sx_q == 0 && sy_q == 0) && r0 >= 1 && r0 <= nr - 2
			&& c0 >= 1 && c0 <= nc - 2;
		cond = !hit_q && zr_q < PW'(ceil_q) && rr_q >= 1 && rr_q <= nr - 2
			&& cc_q >= 1 && cc_q <= nc - 2;
		dxc = gx_q + oxdx - xp_q;
		dyr = gy_q + oydy - yp_q;
		yv  = yp_q + t1_q;
		xv  = xp_q + t1_q;
		ady = (yv - gy_q < 0) ? gy_q - yv : yv - gy_q;
		adx = (xv - gx_q < 0) ? gx_q - xv : xv - gx_q;
		col_dec = xmaj ? (sy_q == 0 || ady < PW'(dy_q))
			: !(sx_q == 0 || adx < PW'(dx_q));
		off  = col_q ? yp_q - gy_q : xp_q - gx_q;
		aint = (col_q ? oy : ox) < 0 ? -off : off;
		trivial = col_q ? (oy == 0 || dy_q == 0) : (ox == 0 || dx_q == 0);
		wr_row = XW'(req.row);
		wr_col = XW'(req.col);
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (start && req.req_type == REQ_QUERY) st_d = ST_INIT;
			ST_INIT: st_d = in_grid ? ST_Z0 : ST_DONE;
			ST_Z0:   st_d = ST_LOOP;
			ST_LOOP: st_d = cond ? ST_R1 : ST_DONE;
			ST_R1:   if (md_done) st_d = ST_DEC;
			ST_DEC:  st_d = (xmaj == col_dec) ? ST_STEP : ST_R2;
			ST_R2:   if (md_done) st_d = ST_STEP;
			ST_STEP: st_d = ST_ZR;
			ST_ZR:   if (md_done) st_d = ST_RD1;
			ST_RD1:  st_d = ST_RD2;
			ST_RD2:  st_d = ST_RD3;
			ST_RD3:  st_d = ST_INT;
			ST_INT:  st_d = trivial ? ST_CMP : ST_IW;
			ST_IW:   if (md_done) st_d = ST_CMP;
			ST_CMP:  st_d = ST_LOOP;
			ST_DONE: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy      = (st_q != ST_IDLE);
		done      = (st_q == ST_DONE);
		rsp       = '{shadowed: hit_q, out_row: qrow_q, out_col: qcol_q};
		ram_we    = (st_q == ST_IDLE) && start && req.req_type == REQ_WRITE
			&& wr_row < XW'(MAX_ROWS) && wr_col < XW'(MAX_COLS);
		ram_waddr = {wr_row[RW-1:0], wr_col[CW-1:0]};
		ram_raddr = {rr_q[RW-1:0], cc_q[CW-1:0]};
		md_start  = 1'b0;
		md_req    = '{a: dxc, b: BW'(sy_q), den: BW'(sx_q), sat: 1'b1};
		case (st_q)
			ST_INIT: ram_raddr = {r0[RW-1:0], c0[CW-1:0]};
			ST_LOOP: begin
				md_start = cond;
				if (!xmaj) md_req = '{a: dyr, b: BW'(sx_q), den: BW'(sy_q), sat: 1'b1};
			end
			ST_DEC: begin
				md_start = (xmaj != col_dec);
				if (!col_dec) md_req = '{a: dyr, b: BW'(sx_q), den: BW'(sy_q), sat: 1'b1};
			end
			ST_STEP: begin
				md_start = 1'b1;
				md_req = col_q ? '{a: dxc, b: BW'(sz_q), den: BW'(sx_q), sat: 1'b1}
					: '{a: dyr, b: BW'(sz_q), den: BW'(sy_q), sat: 1'b1};
			end
			ST_RD2: begin
				ram_raddr = col_q ? {RW'(rr_q + oy), cc_q[CW-1:0]}
					: {rr_q[RW-1:0], CW'(cc_q + ox)};
			end
			ST_INT: begin
				md_start = !trivial;
				md_req = '{a: aint, b: BW'(z2_q) - BW'(z1_q),
					den: col_q ? $signed(BW'(dy_q)) : $signed(BW'(dx_q)), sat: 1'b0};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			hit_q  <= 1'b0;
			sx_q   <= SUN_X_RST;
			sy_q   <= SUN_Y_RST;
			sz_q   <= SUN_Z_RST;
			dx_q   <= CELL_D_RST;
			dy_q   <= CELL_D_RST;
			rows_q <= USED_RST;
			cols_q <= USED_RST;
			ceil_q <= CEILING_RST;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_idx))
					CFG_SUN_X:   sx_q   <= cfg_wdata[17:0];
					CFG_SUN_Y:   sy_q   <= cfg_wdata[17:0];
					CFG_SUN_Z:   sz_q   <= cfg_wdata[17:0];
					CFG_CELL_DX: dx_q   <= cfg_wdata;
					CFG_CELL_DY: dy_q   <= cfg_wdata;
					CFG_ROWS:    rows_q <= cfg_wdata[8:0];
					CFG_COLS:    cols_q <= cfg_wdata[8:0];
					CFG_CEILING: ceil_q <= cfg_wdata;
					default: ;
				endcase
			end
			case (st_q)
				ST_INIT: hit_q <= 1'b0;
				ST_CMP:  hit_q <= zt_q > (NW + 1)'(zr_q);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				qrow_q <= req.row;
				qcol_q <= req.col;
			end
			ST_INIT: begin
				rr_q <= r0;
				cc_q <= c0;
				gx_q <= PW'({8'd0, dx_q} * {24'd0, qcol_q});
				gy_q <= PW'({8'd0, dy_q} * {24'd0, qrow_q});
				xp_q <= PW'({8'd0, dx_q} * {24'd0, qcol_q});
				yp_q <= PW'({8'd0, dy_q} * {24'd0, qrow_q});
			end
			ST_Z0: zr_q <= PW'($signed(ram_rdata));
			ST_R1: if (md_done) t1_q <= PW'(md_q);
			ST_DEC: begin
				col_q <= col_dec;
				np_q  <= xmaj ? yv : xv;
			end
			ST_R2: if (md_done) np_q <= (col_q ? yp_q : xp_q) + PW'(md_q);
			ST_STEP: begin
				if (col_q) begin
					cc_q <= cc_q + ox;
					gx_q <= gx_q + oxdx;
					xp_q <= gx_q + oxdx;
					yp_q <= np_q;
				end else begin
					rr_q <= rr_q + oy;
					gy_q <= gy_q + oydy;
					yp_q <= gy_q + oydy;
					xp_q <= np_q;
				end
			end
			ST_ZR:  if (md_done) zr_q <= zr_q + PW'(md_q);
			ST_RD2: z1_q <= ram_rdata;
			ST_RD3: z2_q <= ram_rdata;
			ST_INT: if (trivial) zt_q <= (NW + 1)'(z1_q);
			ST_IW:  if (md_done) zt_q <= (NW + 1)'(z1_q) + (NW + 1)'(md_q);
			default: ;
		endcase
	end

	a_md_idle: assert property (@(posedge clk) disable iff (!arst_n)
		md_start |-> !md_busy) else $error("multiply/divide started while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("block still busy after a result");
	a_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !busy) else $error("store written during a query");
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.req_type == REQ_QUERY) |=> busy)
		else $error("query transaction not taken");

endmodule
